### rtl/pfmf_pkg.sv
// pfmf_pkg: shared types and constants of the pump flow model filter
// used by every module under rtl/ but pfmf_mul, depends on nothing
package pfmf_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CUBIC  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_SQUARE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_LINEAR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME   = 3'd5;

  localparam logic [15:0] GAIN_RESET = 16'd6554;
  localparam logic [15:0] STEP_RESET = 16'd655;

  // field widths
  localparam int unsigned PRESSURE_W = 16;
  localparam int unsigned DUTY_W     = 15;
  localparam int unsigned FLOW_W     = 31;
  localparam int unsigned VOLUME_W   = 48;
  localparam int unsigned ACC_W      = 62;

  localparam logic [FLOW_W-1:0]   FLOW_MAX   = 31'h7FFF_FFFF;
  localparam logic [VOLUME_W-1:0] VOLUME_MAX = 48'hFFFF_FFFF_FFFF;

  // constant operands of the shared multiplier
  localparam logic signed [31:0] OFFSET_SCALE = 32'sh0001_0000;
  // ceil(2^28 / 25): exact floor(n / 25) for n below 2^23
  localparam logic signed [31:0] DIV25_RECIP  = 32'sd10737419;
  // (q * duty) >> 10 at or above 25 * 2^31 saturates the raw flow
  localparam logic [51:0] RAW_SAT_LIMIT = 52'd53687091200;

  typedef struct packed {
    logic signed [31:0] coef_cubic;
    logic signed [31:0] coef_square;
    logic signed [31:0] coef_linear;
    logic signed [31:0] coef_offset;
    logic [15:0]        filter_gain;
    logic [15:0]        step_time;
  } cfg_t;

endpackage

### rtl/pump_flow_model_filter_unit.sv
// Pump flow model filter: one sample of pressure and duty in, one item
// of filtered flow and accumulated volume out. An item occupies the shared
// 32x32 multiplier sequence from acceptance until the output register takes
// it; the result step waits while that register stays full. s_tready is low
// for that whole time, so a new sample is taken only after the last item is
// handed over. The finished item waits in an output register, so the next
// sample is taken while it is still unread. Configuration writes are taken
// every cycle. Depends on pfmf_pkg, pfmf_cfg, pfmf_core and pfmf_mul.
module pump_flow_model_filter_unit (
  input  logic                             clk,
  input  logic                             rst,
  // slave stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [31:0]                      s_tdata,   // pressure[15:0], duty_cycle[30:16]
  input  logic                             s_tuser,   // clear_state
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pfmf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_data,
  // master stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [79:0]                      m_tdata    // flow_rate[30:0], volume[78:31]
);

  pfmf_pkg::cfg_t cfg;

  logic                                res_valid;
  logic                                res_ready;
  logic [pfmf_pkg::FLOW_W-1:0]         res_flow;
  logic [pfmf_pkg::VOLUME_W-1:0]       res_volume;

  pfmf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pfmf_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .pressure    (s_tdata[15:0]),
    .duty_cycle  (s_tdata[30:16]),
    .clear_state (s_tuser),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_flow    (res_flow),
    .res_volume  (res_volume)
  );

  // output register frees the core as soon as an item is handed over
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {1'b0, res_volume, res_flow};
    end
  end

endmodule

### rtl/pfmf_cfg.sv
// pfmf_cfg: configuration register file of the pump flow model filter
// depends on pfmf_pkg for register indexes, reset values and cfg_t
module pfmf_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pfmf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_data,
  output pfmf_pkg::cfg_t                   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_cubic  <= '0;
      cfg.coef_square <= '0;
      cfg.coef_linear <= '0;
      cfg.coef_offset <= '0;
      cfg.filter_gain <= pfmf_pkg::GAIN_RESET;
      cfg.step_time   <= pfmf_pkg::STEP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        pfmf_pkg::REG_COEF_CUBIC:  cfg.coef_cubic  <= $signed(cfg_data);
        pfmf_pkg::REG_COEF_SQUARE: cfg.coef_square <= $signed(cfg_data);
        pfmf_pkg::REG_COEF_LINEAR: cfg.coef_linear <= $signed(cfg_data);
        pfmf_pkg::REG_COEF_OFFSET: cfg.coef_offset <= $signed(cfg_data);
        pfmf_pkg::REG_FILTER_GAIN: cfg.filter_gain <= cfg_data[15:0];
        pfmf_pkg::REG_STEP_TIME:   cfg.step_time   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/pfmf_mul.sv
// pfmf_mul: shared signed 32x32 multiplier with registered product
// no package dependency
module pfmf_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

### rtl/pfmf_core.sv
// pfmf_core: sequencer and datapath around the shared multiplier
// depends on pfmf_pkg and instantiates pfmf_mul
module pfmf_core (
  input  logic                              clk,
  input  logic                              rst,
  input  pfmf_pkg::cfg_t                    cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pfmf_pkg::PRESSURE_W-1:0]   pressure,
  input  logic [pfmf_pkg::DUTY_W-1:0]       duty_cycle,
  input  logic                              clear_state,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic [pfmf_pkg::FLOW_W-1:0]       res_flow,
  output logic [pfmf_pkg::VOLUME_W-1:0]     res_volume
);

  typedef enum logic [18:0] {
    S_IDLE = 19'h00001,
    S_PP   = 19'h00002,
    S_P3   = 19'h00004,
    S_C3   = 19'h00008,
    S_C2   = 19'h00010,
    S_C1   = 19'h00020,
    S_C0   = 19'h00040,
    S_QH   = 19'h00080,
    S_QHM  = 19'h00100,
    S_QLM  = 19'h00200,
    S_SUM  = 19'h00400,
    S_D1   = 19'h00800,
    S_R1   = 19'h01000,
    S_D2   = 19'h02000,
    S_MA   = 19'h04000,
    S_MB   = 19'h08000,
    S_MIX  = 19'h10000,
    S_VM   = 19'h20000,
    S_VOL  = 19'h40000
  } state_t;

  state_t state, state_next;

  logic [14:0]                        p;
  logic [pfmf_pkg::DUTY_W-1:0]        duty;
  logic [23:0]                        p2;
  logic signed [pfmf_pkg::ACC_W-1:0]  acc;
  logic [43:0]                        q;
  logic [35:0]                        yreg;
  logic                               sat;
  logic [13:0]                        q1;
  logic [4:0]                         r1;
  logic [pfmf_pkg::FLOW_W-1:0]        flow;
  logic [pfmf_pkg::VOLUME_W-1:0]      vol;

  logic signed [31:0]                 mul_a;
  logic signed [31:0]                 mul_b;
  logic signed [63:0]                 prod;
  logic signed [pfmf_pkg::ACC_W-1:0]  prod_acc;
  logic signed [pfmf_pkg::ACC_W-1:0]  acc_sum;
  logic [43:0]                        q_next;
  logic [17:0]                        r1_full;
  logic [pfmf_pkg::FLOW_W-1:0]        raw;
  logic [16:0]                        gain_comp;
  logic [pfmf_pkg::FLOW_W-1:0]        mix;
  logic [pfmf_pkg::VOLUME_W:0]        vol_sum;
  logic [pfmf_pkg::VOLUME_W-1:0]      vol_next;
  logic                               in_fire;

  pfmf_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign res_valid = (state == S_VOL);
  assign res_flow  = flow;
  assign res_volume = vol_next;

  assign prod_acc = $signed(prod[pfmf_pkg::ACC_W-1:0]);
  assign acc_sum  = acc + prod_acc;

  // polynomial sum is below 2^60, so q fits 44 bits
  assign q_next = (acc_sum[pfmf_pkg::ACC_W-1] || (acc_sum == '0)) ? '0 : acc_sum[59:16];

  // remainder of the upper digit divided by 25
  assign r1_full = yreg[35:18] - ({4'b0, prod[41:28]} * 18'd25);

  assign raw = sat ? pfmf_pkg::FLOW_MAX : {q1[12:0], prod[45:28]};

  assign gain_comp = 17'h10000 - {1'b0, cfg.filter_gain};

  assign mix = (acc_sum[61:16] > {15'b0, pfmf_pkg::FLOW_MAX}) ? pfmf_pkg::FLOW_MAX
                                                             : acc_sum[46:16];

  assign vol_sum  = {1'b0, vol} + {18'b0, prod[46:16]};
  assign vol_next = vol_sum[pfmf_pkg::VOLUME_W] ? pfmf_pkg::VOLUME_MAX
                                                : vol_sum[pfmf_pkg::VOLUME_W-1:0];

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_PP: begin
        mul_a = {17'b0, p};
        mul_b = {17'b0, p};
      end
      S_P3: begin
        mul_a = {8'b0, prod[29:6]};
        mul_b = {17'b0, p};
      end
      S_C3: begin
        mul_a = cfg.coef_cubic;
        mul_b = {4'b0, prod[38:11]};
      end
      S_C2: begin
        mul_a = cfg.coef_square;
        mul_b = {8'b0, p2};
      end
      S_C1: begin
        mul_a = cfg.coef_linear;
        mul_b = {12'b0, p, 5'b0};
      end
      S_C0: begin
        mul_a = cfg.coef_offset;
        mul_b = pfmf_pkg::OFFSET_SCALE;
      end
      S_QHM: begin
        mul_a = {10'b0, q[43:22]};
        mul_b = {17'b0, duty};
      end
      S_QLM: begin
        mul_a = {10'b0, q[21:0]};
        mul_b = {17'b0, duty};
      end
      S_D1: begin
        mul_a = {14'b0, yreg[35:18]};
        mul_b = pfmf_pkg::DIV25_RECIP;
      end
      S_D2: begin
        mul_a = {9'b0, r1, yreg[17:0]};
        mul_b = pfmf_pkg::DIV25_RECIP;
      end
      S_MA: begin
        mul_a = {16'b0, cfg.filter_gain};
        mul_b = {1'b0, raw};
      end
      S_MB: begin
        mul_a = {15'b0, gain_comp};
        mul_b = {1'b0, flow};
      end
      // held while the result waits so the product stays put
      S_VM, S_VOL: begin
        mul_a = {16'b0, cfg.step_time};
        mul_b = {1'b0, flow};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_fire) state_next = S_PP;
      S_PP:    state_next = S_P3;
      S_P3:    state_next = S_C3;
      S_C3:    state_next = S_C2;
      S_C2:    state_next = S_C1;
      S_C1:    state_next = S_C0;
      S_C0:    state_next = S_QH;
      S_QH:    state_next = S_QHM;
      S_QHM:   state_next = S_QLM;
      S_QLM:   state_next = S_SUM;
      S_SUM:   state_next = S_D1;
      S_D1:    state_next = S_R1;
      S_R1:    state_next = S_D2;
      S_D2:    state_next = S_MA;
      S_MA:    state_next = S_MB;
      S_MB:    state_next = S_MIX;
      S_MIX:   state_next = S_VM;
      S_VM:    state_next = S_VOL;
      S_VOL:   if (res_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      flow <= '0;
      vol  <= '0;
    end else begin
      if (in_fire && clear_state) begin
        flow <= '0;
        vol  <= '0;
      end
      if (state == S_MIX) begin
        flow <= mix;
      end
      if (res_valid && res_ready) begin
        vol <= vol_next;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          p    <= pressure[15] ? '0 : pressure[14:0];
          duty <= duty_cycle;
        end
      end
      S_P3:  p2  <= prod[29:6];
      S_C2:  acc <= prod_acc;
      S_C1:  acc <= acc_sum;
      S_C0:  acc <= acc_sum;
      S_QH:  q   <= q_next;
      S_QLM: acc <= $signed({prod[39:0], 22'b0});
      S_SUM: begin
        sat  <= (acc_sum[61:10] >= pfmf_pkg::RAW_SAT_LIMIT);
        yreg <= acc_sum[45:10];
      end
      S_R1: begin
        q1 <= prod[41:28];
        r1 <= r1_full[4:0];
      end
      S_MB:  acc <= prod_acc;
      default: ;
    endcase
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("core still ready after taking an item");

  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> ##18 (state == S_VOL))
    else $error("sequence did not reach the result step on time");

  a_volume_monotonic: assert property (@(posedge clk) disable iff (rst)
    !(in_fire && clear_state) |=> (vol >= $past(vol)))
    else $error("volume dropped without a clear");
`endif

endmodule

### bench/tb_pump_flow_model_filter_unit.sv
// tb_pump_flow_model_filter_unit: self-checking bench for the pump flow model filter,
// predicts flow and volume per accepted sample and compares each output item
// depends on pfmf_pkg and pump_flow_model_filter_unit
module tb_pump_flow_model_filter_unit;

  localparam logic [pfmf_pkg::CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
  localparam logic [pfmf_pkg::CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;
  localparam logic [63:0] DUTY_FULL = 64'd25600;
  localparam logic [14:0] DUTY_TOP = 15'h7FFF;

  typedef struct packed {
    logic signed [15:0] pressure;
    logic [14:0]        duty;
    logic               clear;
  } sample_t;

  typedef struct packed {
    logic [pfmf_pkg::FLOW_W-1:0]   flow;
    logic [pfmf_pkg::VOLUME_W-1:0] volume;
  } flow_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pfmf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [79:0] m_tdata;

  // predictor copy of the registers and the filter state
  longint coef_cubic_q = 0;
  longint coef_square_q = 0;
  longint coef_linear_q = 0;
  longint coef_offset_q = 0;
  logic [15:0] gain_q = pfmf_pkg::GAIN_RESET;
  logic [15:0] step_q = pfmf_pkg::STEP_RESET;
  logic [pfmf_pkg::FLOW_W-1:0] flow_st = '0;
  logic [pfmf_pkg::VOLUME_W-1:0] vol_st = '0;

  sample_t sample_q[$];
  flow_result_t flow_expect_q[$];
  sample_t cur_sample;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned err_count = 0;

  pump_flow_model_filter_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // one sample through the flow polynomial, duty scaling, low-pass and integrator
  function automatic flow_result_t advance_flow_model(sample_t smp);
    logic [63:0] p, p2, p3, q, raw, mix, inc;
    longint poly;
    flow_result_t res;
    if (smp.clear) begin
      flow_st = '0;
      vol_st = '0;
    end
    p = smp.pressure[15] ? 64'd0 : {48'd0, smp.pressure};
    p2 = (p * p) >> 6;
    p3 = (p2 * p) >> 11;
    poly = coef_cubic_q * $signed(p3) + coef_square_q * $signed(p2)
         + coef_linear_q * $signed(p << 5) + coef_offset_q * 64'sd65536;
    if (poly <= 0) begin
      q = 64'd0;
    end else begin
      q = poly >>> 16;
    end
    raw = (q * {49'd0, smp.duty}) / DUTY_FULL;
    if (raw > pfmf_pkg::FLOW_MAX) raw = pfmf_pkg::FLOW_MAX;
    mix = ({48'd0, gain_q} * raw + (64'd65536 - {48'd0, gain_q}) * {33'd0, flow_st}) >> 16;
    if (mix > pfmf_pkg::FLOW_MAX) mix = pfmf_pkg::FLOW_MAX;
    flow_st = mix[pfmf_pkg::FLOW_W-1:0];
    inc = ({33'd0, flow_st} * {48'd0, step_q}) >> 16;
    if (inc > {16'd0, (pfmf_pkg::VOLUME_MAX - vol_st)}) begin
      vol_st = pfmf_pkg::VOLUME_MAX;
    end else begin
      vol_st = vol_st + inc[pfmf_pkg::VOLUME_W-1:0];
    end
    res.flow = flow_st;
    res.volume = vol_st;
    return res;
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) flow_expect_q.push_back(advance_flow_model(cur_sample));
      if (sample_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        cur_sample = sample_q.pop_front();
        s_tdata <= {1'b0, cur_sample.duty, cur_sample.pressure};
        s_tuser <= cur_sample.clear;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    flow_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (flow_expect_q.size() == 0) begin
          report_mismatch("output item with nothing expected");
        end else begin
          want = flow_expect_q.pop_front();
          if (m_tdata[30:0] !== want.flow) begin
            report_mismatch($sformatf("flow_rate got %h want %h", m_tdata[30:0], want.flow));
          end
          if (m_tdata[78:31] !== want.volume) begin
            report_mismatch($sformatf("volume got %h want %h", m_tdata[78:31], want.volume));
          end
        end
      end
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic write_reg(input logic [pfmf_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      pfmf_pkg::REG_COEF_CUBIC:  coef_cubic_q = longint'($signed(data));
      pfmf_pkg::REG_COEF_SQUARE: coef_square_q = longint'($signed(data));
      pfmf_pkg::REG_COEF_LINEAR: coef_linear_q = longint'($signed(data));
      pfmf_pkg::REG_COEF_OFFSET: coef_offset_q = longint'($signed(data));
      pfmf_pkg::REG_FILTER_GAIN: gain_q = data[15:0];
      pfmf_pkg::REG_STEP_TIME:   step_q = data[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] c3, input logic [31:0] c2,
                            input logic [31:0] c1, input logic [31:0] c0,
                            input logic [15:0] gain, input logic [15:0] step);
    write_reg(pfmf_pkg::REG_COEF_CUBIC, c3);
    write_reg(pfmf_pkg::REG_COEF_SQUARE, c2);
    write_reg(pfmf_pkg::REG_COEF_LINEAR, c1);
    write_reg(pfmf_pkg::REG_COEF_OFFSET, c0);
    // upper data bits of the narrow registers carry noise
    write_reg(pfmf_pkg::REG_FILTER_GAIN, {16'($urandom_range(65535)), gain});
    write_reg(pfmf_pkg::REG_STEP_TIME, {16'($urandom_range(65535)), step});
  endtask

  task automatic push_sample(input logic [15:0] p, input logic [14:0] d, input logic c);
    sample_t smp;
    smp.pressure = p;
    smp.duty = d;
    smp.clear = c;
    sample_q.push_back(smp);
  endtask

  // waits until no sample is queued or in flight and every result has come;
  // looked at on the falling edge so the driver's updates have settled
  task automatic wait_drained();
    do @(negedge clk);
    while (sample_q.size() != 0 || s_tvalid || flow_expect_q.size() != 0);
  endtask

  function automatic logic [31:0] random_coef();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      default: return $signed($urandom) >>> $urandom_range(31);
    endcase
  endfunction

  function automatic logic [15:0] random_q16();
    case ($urandom_range(5))
      0: return 16'h0;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    src_idle_pct = 14;
    snk_idle_pct = 62;

    // moderate curve, fastest filter and longest step
    set_config(-32'sd655, 32'sd13107, 32'sd98304, 32'sd131072, 16'hFFFF, 16'hFFFF);
    write_reg(REG_UNUSED_6, $urandom);
    write_reg(REG_UNUSED_7, $urandom);
    push_sample(16'h8000, 15'd25600, 1'b0);
    push_sample(16'hFFFF, 15'd25600, 1'b0);
    push_sample(16'h0000, 15'd25600, 1'b0);
    push_sample(16'h0001, 15'd0, 1'b0);
    push_sample(16'h7FFF, 15'd25600, 1'b0);
    push_sample(16'h7FFF, DUTY_TOP, 1'b0);
    push_sample(16'd18432, 15'd12800, 1'b0);
    push_sample(16'd4096, 15'd25600, 1'b1);
    push_sample(16'h7FFF, DUTY_TOP, 1'b1);
    wait_drained();

    // polynomial below zero everywhere, filter and integrator frozen
    set_config(32'h0, 32'h0, 32'h0, 32'h8000_0000, 16'h0, 16'h0);
    push_sample(16'd16384, 15'd25600, 1'b0);
    push_sample(16'h0000, DUTY_TOP, 1'b0);
    push_sample(16'hFFFB, 15'd100, 1'b1);
    wait_drained();

    // largest coefficients drive the raw flow into saturation
    set_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               pfmf_pkg::GAIN_RESET, pfmf_pkg::STEP_RESET);
    push_sample(16'h7FFF, DUTY_TOP, 1'b0);
    push_sample(16'h7FFF, 15'd25600, 1'b0);
    push_sample(16'd20000, 15'd1, 1'b0);
    push_sample(16'h0001, DUTY_TOP, 1'b0);
    push_sample(16'h7FFF, 15'd0, 1'b1);
    wait_drained();

    set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h0001);
    push_sample(16'h7FFF, 15'd25600, 1'b0);
    push_sample(16'd100, 15'd25600, 1'b0);
    push_sample(16'd2048, 15'd25600, 1'b0);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          src_idle_pct = 14;
          snk_idle_pct = 62;
        end
        1: begin
          src_idle_pct = 62;
          snk_idle_pct = 14;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      set_config(random_coef(), random_coef(), random_coef(), random_coef(),
                 random_q16(), random_q16());
      write_reg($urandom_range(1) ? REG_UNUSED_6 : REG_UNUSED_7, $urandom);
      // two halves with a full drain in between
      for (int half = 0; half < 2; half++) begin
        for (int n = 0; n < 150; n++) begin
          logic [15:0] p;
          logic [14:0] d;
          case ($urandom_range(9))
            0: p = 16'h8000 | 16'($urandom_range(32767));
            1: p = $urandom_range(1) ? 16'h7FFF : 16'h0000;
            2, 3, 4: p = 16'($urandom_range(4095));
            default: p = 16'($urandom_range(32767));
          endcase
          case ($urandom_range(19))
            0: d = $urandom_range(1) ? 15'd0 : DUTY_TOP;
            1, 2: d = 15'($urandom_range(32767, 25601));
            default: d = 15'($urandom_range(25600));
          endcase
          push_sample(p, d, $urandom_range(49) == 0);
        end
        wait_drained();
      end
    end

    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### pump_flow_model_filter_unit.f
rtl/pfmf_pkg.sv
rtl/pfmf_cfg.sv
rtl/pfmf_mul.sv
rtl/pfmf_core.sv
rtl/pump_flow_model_filter_unit.sv
bench/tb_pump_flow_model_filter_unit.sv
